FILE: sv/frame_crc8_escape_counter_unit_defines.svh
// Assertion macros used by the frame CRC-8 escape counter core module.
`ifndef FRAME_CRC8_ESCAPE_COUNTER_UNIT_DEFINES_SVH
`define FRAME_CRC8_ESCAPE_COUNTER_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define FCE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define FCE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/fce_pkg.sv
// Package with types, constants and functions of the frame CRC-8 escape counter.
`default_nettype none

package fce_pkg;

    localparam int unsigned MAX_FRAME_BYTES = 256;
    localparam int unsigned TALLY_W         = 9;
    localparam int unsigned TALLY_MAX       = (1 << TALLY_W) - 1;
    localparam logic [TALLY_W-1:0] TALLY_LIMIT =
        TALLY_W'((MAX_FRAME_BYTES > TALLY_MAX) ? TALLY_MAX : MAX_FRAME_BYTES);
    localparam logic [7:0] CRC_POLY_RESET = 8'hA6;

    // One input item as held in the input register.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
        logic       last_byte;
    } t_item;

    // Input register contents offered to the compute stage.
    typedef struct packed {
        logic  valid;
        t_item item;
    } t_stage;

    // One result item.
    typedef struct packed {
        logic               needs_escape;
        logic [7:0]         crc_value;
        logic               crc_needs_escape;
        logic [TALLY_W-1:0] escape_total;
    } t_result;

    // A byte is reserved if it is 0x08-0x0B, 0x12-0x13 or 0x7D.
    function automatic logic is_reserved(input logic [7:0] b);
        return b inside {[8'h08:8'h0B], [8'h12:8'h13], 8'h7D};
    endfunction

    // Eight unrolled MSB-first shift steps of the CRC over one byte.
    function automatic logic [7:0] crc8_fold(input logic [7:0] crc, input logic [7:0] data,
                                             input logic [7:0] poly);
        logic [7:0] c;
        c = crc ^ data;
        for (int i = 0; i < 8; i++) begin
            c = c[7] ? ({c[6:0], 1'b0} ^ poly) : {c[6:0], 1'b0};
        end
        return c;
    endfunction

    // Saturating increment of the escape count.
    function automatic logic [TALLY_W-1:0] tally_bump(input logic [TALLY_W-1:0] t,
                                                     input logic en);
        return (en && (t < TALLY_LIMIT)) ? t + TALLY_W'(1) : t;
    endfunction

endpackage

`default_nettype wire

FILE: sv/fce_if.sv
// Channel interfaces of the frame CRC-8 escape counter.
`default_nettype none

interface fce_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;
    modport source (output valid, data_byte, first_byte, last_byte, input ready);
    modport sink   (input valid, data_byte, first_byte, last_byte, output ready);
endinterface

interface fce_out_if;
    logic                            valid;
    logic                            ready;
    logic                            needs_escape;
    logic [7:0]                      crc_value;
    logic                            crc_needs_escape;
    logic [fce_pkg::TALLY_W-1:0]     escape_total;
    modport source (output valid, needs_escape, crc_value, crc_needs_escape, escape_total,
                    input ready);
    modport sink   (input valid, needs_escape, crc_value, crc_needs_escape, escape_total,
                    output ready);
endinterface

interface fce_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] crc_polynomial;
    modport source (output valid, crc_polynomial, input ready);
    modport sink   (input valid, crc_polynomial, output ready);
endinterface

`default_nettype wire

FILE: sv/frame_crc8_escape_counter_unit.sv
// Top level of the frame CRC-8 escape counter.
// Usage:
// Bytes of a message arrive on i_item, one item per byte, with first_byte
// set on the opening byte and last_byte on the closing byte. Each item gives
// exactly one item on o_result: the escape flag of the byte, the running
// CRC-8 after that byte, on the last byte the escape flag of the finished
// CRC byte, and the saturating count of escaped bytes so far.
// The CRC polynomial is written through i_cfg, which is always ready; write
// it only while no item is in flight.
// Flow: an accepted item is held in the input register, then moves into the
// result register once that register is free, and is shown on o_result from
// there. The block takes one item per cycle while o_result is taken, set by
// the combinational CRC fold and compare logic between the two registers,
// which also carries the running CRC and count from item to item.
// Reset: the polynomial returns to 0xA6, the CRC and count clear to zero,
// and both channels are empty.
// Stalls: when o_result is not taken, the result register holds; the input
// register then fills and i_item.ready drops until the result is taken.
`default_nettype none

module frame_crc8_escape_counter_unit (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    fce_in_if.sink      i_item,
    fce_cfg_if.sink     i_cfg,
    fce_out_if.source   o_result
);

    logic [7:0]         r_poly;
    fce_pkg::t_stage    stage;
    logic               take;

    // The polynomial register accepts a write in every cycle.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_poly <= fce_pkg::CRC_POLY_RESET;
        end else if (i_cfg.valid) begin
            r_poly <= i_cfg.crc_polynomial;
        end
    end

    fce_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_item),
        .i_take  (take),
        .o_stage (stage)
    );

    fce_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_poly   (r_poly),
        .i_stage  (stage),
        .o_take   (take),
        .o_result (o_result)
    );

endmodule

`default_nettype wire

FILE: sv/fce_in_stage.sv
// Input register that captures one item from the input channel.
`default_nettype none

module fce_in_stage (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    fce_in_if.sink              i_item,
    input  wire logic           i_take,
    output fce_pkg::t_stage     o_stage
);

    logic           r_valid;
    logic           n_valid;
    fce_pkg::t_item r_item;
    logic           load;

    // The register frees up whenever the compute stage takes its item.
    assign i_item.ready = !r_valid || i_take;
    assign load         = i_item.valid && i_item.ready;

    always_comb begin
        n_valid = r_valid;
        if (load) begin
            n_valid = 1'b1;
        end else if (i_take) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_item.data_byte  <= i_item.data_byte;
            r_item.first_byte <= i_item.first_byte;
            r_item.last_byte  <= i_item.last_byte;
        end
    end

    assign o_stage.valid = r_valid;
    assign o_stage.item  = r_item;

endmodule

`default_nettype wire

FILE: sv/fce_core.sv
// CRC and escape count update with the result register.
`default_nettype none

`include "frame_crc8_escape_counter_unit_defines.svh"

module fce_core (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic [7:0]     i_poly,
    input  wire fce_pkg::t_stage i_stage,
    output logic                o_take,
    fce_out_if.source           o_result
);

    logic [7:0]                     r_crc;
    logic [7:0]                     n_crc;
    logic [fce_pkg::TALLY_W-1:0]    r_tally;
    logic [fce_pkg::TALLY_W-1:0]    n_tally;
    logic                           r_out_valid;
    logic                           n_out_valid;
    fce_pkg::t_result               r_res;
    fce_pkg::t_result               n_res;
    logic [7:0]                     crc_start;
    logic [7:0]                     crc_after;
    logic [fce_pkg::TALLY_W-1:0]    tally_start;
    logic [fce_pkg::TALLY_W-1:0]    tally_mid;
    logic                           esc;
    logic                           crc_esc;
    logic                           out_free;

    assign out_free = !r_out_valid || o_result.ready;
    assign o_take   = i_stage.valid && out_free;

    always_comb begin
        crc_start   = i_stage.item.first_byte ? 8'h00 : r_crc;
        tally_start = i_stage.item.first_byte ? '0 : r_tally;
        crc_after   = fce_pkg::crc8_fold(crc_start, i_stage.item.data_byte, i_poly);
        esc         = fce_pkg::is_reserved(i_stage.item.data_byte);
        crc_esc     = i_stage.item.last_byte && fce_pkg::is_reserved(crc_after);
        tally_mid   = fce_pkg::tally_bump(tally_start, esc);

        n_res.needs_escape     = esc;
        n_res.crc_value        = crc_after;
        n_res.crc_needs_escape = crc_esc;
        n_res.escape_total     = fce_pkg::tally_bump(tally_mid, crc_esc);

        // Folding the finished CRC into itself always leaves zero.
        n_crc   = i_stage.item.last_byte ? 8'h00 : crc_after;
        n_tally = n_res.escape_total;
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_take) begin
            n_out_valid = 1'b1;
        end else if (o_result.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc       <= 8'h00;
            r_tally     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (o_take) begin
                r_crc   <= n_crc;
                r_tally <= n_tally;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_res <= n_res;
        end
    end

    assign o_result.valid            = r_out_valid;
    assign o_result.needs_escape     = r_res.needs_escape;
    assign o_result.crc_value        = r_res.crc_value;
    assign o_result.crc_needs_escape = r_res.crc_needs_escape;
    assign o_result.escape_total     = r_res.escape_total;

    `FCE_ASSERT_NEXT(a_crc_zero_after_last, i_clk, i_rst_n,
        o_take && i_stage.item.last_byte, r_crc == 8'h00, "CRC not cleared after last byte")
    `FCE_ASSERT_NOW(a_tally_in_range, i_clk, i_rst_n,
        1'b1, r_tally <= fce_pkg::TALLY_LIMIT, "escape count above its limit")
    `FCE_ASSERT_NEXT(a_tally_monotonic, i_clk, i_rst_n,
        o_take && !i_stage.item.first_byte, r_tally >= $past(r_tally),
        "escape count dropped without a first byte")
    `FCE_ASSERT_NEXT(a_state_matches_result, i_clk, i_rst_n,
        o_take, r_tally == r_res.escape_total, "stored count differs from result")

endmodule

`default_nettype wire

FILE: tb/tb.sv
// Self-checking testbench of the frame CRC-8 escape counter with random flow control.
`timescale 1ns / 100ps

module tb;

    // Timing and run length.
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 150;

    // The escape count stops at the frame size, but never above what nine bits hold.
    localparam logic [fce_pkg::TALLY_W-1:0] ESCAPE_CEILING =
        fce_pkg::TALLY_W'((fce_pkg::MAX_FRAME_BYTES > 511) ? 511 : fce_pkg::MAX_FRAME_BYTES);

    // Bytes that would have to be stuffed on the link.
    localparam logic [7:0] RESERVED_BYTES [7] = '{
        8'h08, 8'h09, 8'h0A, 8'h0B, 8'h12, 8'h13, 8'h7D
    };

    logic i_clk;
    logic i_rst_n;

    fce_in_if  item_if ();
    fce_out_if result_if ();
    fce_cfg_if cfg_if ();

    frame_crc8_escape_counter_unit u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_if),
        .i_cfg    (cfg_if),
        .o_result (result_if)
    );

    // Bytes waiting to be offered, and the results the block owes us, oldest first.
    fce_pkg::t_item   pending_bytes [$];
    fce_pkg::t_result owed_results [$];

    // Shadow of the block's state: polynomial, running CRC and escape count.
    logic [7:0]                  poly_shadow;
    logic [7:0]                  crc_shadow;
    logic [fce_pkg::TALLY_W-1:0] escape_shadow;

    // Flow control knobs, in percent of cycles spent idle on each side.
    int send_idle_pct;
    int recv_idle_pct;
    int hold_requests;
    int holds_done;
    int hold_left;

    int error_count;
    int cycle_count;
    int checked_results;
    int frames_closed;
    int data_escapes;
    int crc_escapes;
    int saturated_counts;
    int input_stalls;
    int poly_settings;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // One MSB-first CRC-8 step over a byte, fed bit by bit.
    function automatic logic [7:0] crc8_step(input logic [7:0] crc_in, input logic [7:0] b,
                                             input logic [7:0] poly);
        logic [7:0] r;
        logic       feedback;
        r = crc_in;
        for (int k = 7; k >= 0; k--) begin
            feedback = r[7] ^ b[k];
            r = {r[6:0], 1'b0} ^ (feedback ? poly : 8'h00);
        end
        return r;
    endfunction

    function automatic logic escape_byte(input logic [7:0] b);
        foreach (RESERVED_BYTES[i]) begin
            if (b == RESERVED_BYTES[i]) begin
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic logic [fce_pkg::TALLY_W-1:0] count_up(
        input logic [fce_pkg::TALLY_W-1:0] t, input logic hit);
        return (hit && t < ESCAPE_CEILING) ? t + 1'b1 : t;
    endfunction

    // Works out the result of one accepted byte and advances the shadow state.
    task automatic predict_frame_byte(input fce_pkg::t_item it, output fce_pkg::t_result r);
        logic [7:0] crc_now;
        if (it.first_byte) begin
            crc_shadow    = '0;
            escape_shadow = '0;
        end
        crc_now            = crc8_step(crc_shadow, it.data_byte, poly_shadow);
        r.needs_escape     = escape_byte(it.data_byte);
        r.crc_needs_escape = 1'b0;
        escape_shadow      = count_up(escape_shadow, r.needs_escape);
        crc_shadow         = crc_now;
        if (it.last_byte) begin
            // The CRC byte itself goes on the link, so it is checked and folded in too.
            r.crc_needs_escape = escape_byte(crc_now);
            escape_shadow      = count_up(escape_shadow, r.crc_needs_escape);
            crc_shadow         = crc8_step(crc_now, crc_now, poly_shadow);
            frames_closed++;
        end
        r.crc_value    = crc_now;
        r.escape_total = escape_shadow;
        data_escapes += r.needs_escape;
        crc_escapes  += r.crc_needs_escape;
        if (escape_shadow == ESCAPE_CEILING) begin
            saturated_counts++;
        end
    endtask

    // Byte driver: offers queued bytes, holds each one until it is taken, and
    // predicts the result of every byte at the edge where it is accepted.
    always @(posedge i_clk) begin : byte_driver
        fce_pkg::t_item   taken;
        fce_pkg::t_item   nxt;
        fce_pkg::t_result owed;
        logic             offer;
        if (!i_rst_n) begin
            item_if.valid      <= 1'b0;
            item_if.data_byte  <= 8'h00;
            item_if.first_byte <= 1'b0;
            item_if.last_byte  <= 1'b0;
        end else begin
            if (item_if.valid && item_if.ready) begin
                taken.data_byte  = item_if.data_byte;
                taken.first_byte = item_if.first_byte;
                taken.last_byte  = item_if.last_byte;
                predict_frame_byte(taken, owed);
                owed_results.push_back(owed);
            end
            if (item_if.valid && !item_if.ready) begin
                input_stalls++;
            end
            // The slot is free when nothing is offered or the offer was just taken.
            if (!item_if.valid || item_if.ready) begin
                offer = pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct;
                if (offer) begin
                    nxt = pending_bytes.pop_front();
                    item_if.data_byte  <= nxt.data_byte;
                    item_if.first_byte <= nxt.first_byte;
                    item_if.last_byte  <= nxt.last_byte;
                end
                item_if.valid <= offer;
            end
        end
    end

    // Long receiver hold-offs, so that the block fills up and stalls its input.
    always @(posedge i_clk) begin : receiver_hold
        if (!i_rst_n) begin
            hold_left  <= 0;
            holds_done <= 0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (holds_done != hold_requests) begin
            hold_left  <= HOLD_CYCLES;
            holds_done <= holds_done + 1;
        end
    end

    // Result monitor: compares every taken result with the oldest one owed.
    always @(posedge i_clk) begin : result_monitor
        fce_pkg::t_result want;
        if (!i_rst_n) begin
            result_if.ready <= 1'b0;
        end else begin
            if (result_if.valid && result_if.ready) begin
                if (owed_results.size() == 0) begin
                    $error("result item arrived with no byte outstanding");
                    error_count++;
                end else begin
                    want = owed_results.pop_front();
                    checked_results++;
                    if (result_if.needs_escape !== want.needs_escape) begin
                        $error("needs_escape: expected %0d, got %0d",
                               want.needs_escape, result_if.needs_escape);
                        error_count++;
                    end
                    if (result_if.crc_value !== want.crc_value) begin
                        $error("crc_value: expected 0x%02h, got 0x%02h",
                               want.crc_value, result_if.crc_value);
                        error_count++;
                    end
                    if (result_if.crc_needs_escape !== want.crc_needs_escape) begin
                        $error("crc_needs_escape: expected %0d, got %0d",
                               want.crc_needs_escape, result_if.crc_needs_escape);
                        error_count++;
                    end
                    if (result_if.escape_total !== want.escape_total) begin
                        $error("escape_total: expected %0d, got %0d",
                               want.escape_total, result_if.escape_total);
                        error_count++;
                    end
                end
            end
            result_if.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin : watchdog
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results still owed",
                     cycle_count, owed_results.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic push_byte(input logic [7:0] b, input logic first, input logic last);
        fce_pkg::t_item it;
        it.data_byte  = b;
        it.first_byte = first;
        it.last_byte  = last;
        pending_bytes.push_back(it);
    endtask

    function automatic logic [7:0] pick_byte(input int reserved_pct);
        if ($urandom_range(99) < reserved_pct) begin
            return RESERVED_BYTES[$urandom_range(6)];
        end
        return 8'($urandom);
    endfunction

    // A well-formed frame has first on its opening byte and last on its closing
    // byte; a broken one carries the flags at random.
    task automatic queue_frame(input int len, input logic well_formed, input int reserved_pct);
        logic first;
        logic last;
        for (int i = 0; i < len; i++) begin
            first = well_formed ? (i == 0) : ($urandom_range(99) < 15);
            last  = well_formed ? (i == len - 1) : ($urandom_range(99) < 15);
            push_byte(pick_byte(reserved_pct), first, last);
        end
    endtask

    // Mostly well-formed frames with random content, the rest broken frames and
    // lone bytes with random flags.
    task automatic queue_random_traffic(input int n_bytes);
        int start;
        int kind;
        start = pending_bytes.size();
        while (pending_bytes.size() < start + n_bytes) begin
            kind = $urandom_range(99);
            if (kind < 80) begin
                queue_frame($urandom_range(24, 1), 1'b1, 25);
            end else if (kind < 92) begin
                queue_frame($urandom_range(12, 1), 1'b0, 25);
            end else begin
                queue_frame(1, 1'b0, 50);
            end
        end
    endtask

    // Sampled between edges, so the driver and monitor have settled for the cycle.
    task automatic wait_until_drained();
        do @(negedge i_clk);
        while (pending_bytes.size() != 0 || item_if.valid || owed_results.size() != 0);
    endtask

    // The polynomial may only change while no byte is in flight.
    task automatic write_polynomial(input logic [7:0] p);
        wait_until_drained();
        @(posedge i_clk);
        cfg_if.valid          <= 1'b1;
        cfg_if.crc_polynomial <= p;
        do @(posedge i_clk);
        while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        poly_shadow = p;
        poly_settings++;
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        @(posedge i_clk);
        send_idle_pct <= send_pct;
        recv_idle_pct <= recv_pct;
    endtask

    task automatic request_hold();
        @(posedge i_clk);
        hold_requests <= hold_requests + 1;
    endtask

    // Main sequence: reset, a directed frame set on the reset polynomial, then
    // random traffic under several polynomials and three flow control regimes.
    initial begin : stimulus
        logic [7:0] crc_escaping_byte;
        item_if.valid         = 1'b0;
        item_if.data_byte     = 8'h00;
        item_if.first_byte    = 1'b0;
        item_if.last_byte     = 1'b0;
        result_if.ready       = 1'b0;
        cfg_if.valid          = 1'b0;
        cfg_if.crc_polynomial = 8'h00;
        poly_shadow   = fce_pkg::CRC_POLY_RESET;
        crc_shadow    = '0;
        escape_shadow = '0;
        send_idle_pct = 31;
        recv_idle_pct = 58;
        hold_requests = 0;
        error_count   = 0;
        cycle_count   = 0;
        poly_settings = 1;
        i_rst_n = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Find a single-byte frame whose finished CRC byte needs stuffing.
        crc_escaping_byte = 8'h00;
        for (int b = 255; b >= 0; b--) begin
            if (escape_byte(crc8_step(8'h00, 8'(b), fce_pkg::CRC_POLY_RESET))) begin
                crc_escaping_byte = 8'(b);
            end
        end

        // Directed part. The opening bytes carry no first flag, so they run on
        // from the state left by reset.
        @(negedge i_clk);
        push_byte(8'h55, 1'b0, 1'b0);
        push_byte(8'h00, 1'b0, 1'b1);
        push_byte(8'hFF, 1'b1, 1'b0);
        foreach (RESERVED_BYTES[i]) begin
            push_byte(RESERVED_BYTES[i], 1'b0, 1'b0);
        end
        // Neighbors of the reserved ranges must not count.
        push_byte(8'h07, 1'b0, 1'b0);
        push_byte(8'h0C, 1'b0, 1'b0);
        push_byte(8'h11, 1'b0, 1'b0);
        push_byte(8'h7E, 1'b0, 1'b0);
        push_byte(8'h80, 1'b0, 1'b1);
        // First and last on one byte, once with an escaping CRC byte.
        push_byte(crc_escaping_byte, 1'b1, 1'b1);
        push_byte(8'hFF, 1'b1, 1'b1);
        // After a closed frame the CRC is zero and the count stays until a first flag.
        push_byte(8'h00, 1'b0, 1'b0);
        push_byte(8'h7D, 1'b0, 1'b1);

        // Sender idles less than the receiver.
        write_polynomial(8'hFF);
        @(negedge i_clk);
        queue_random_traffic(100);
        request_hold();

        // Receiver idles less than the sender. A frame of reserved bytes longer
        // than the count limit drives the count into saturation.
        write_polynomial(8'h00);
        set_idling(58, 31);
        @(negedge i_clk);
        queue_frame(280, 1'b1, 100);
        queue_random_traffic(80);

        write_polynomial(8'($urandom));
        @(negedge i_clk);
        queue_random_traffic(100);
        request_hold();

        // Neither side idles; the hold-off here is the only back-pressure.
        write_polynomial(8'h01);
        set_idling(0, 0);
        @(negedge i_clk);
        queue_random_traffic(120);
        request_hold();

        write_polynomial(8'h80);
        @(negedge i_clk);
        queue_random_traffic(80);
        queue_frame(280, 1'b1, 100);

        write_polynomial(fce_pkg::CRC_POLY_RESET);
        @(negedge i_clk);
        queue_random_traffic(40);

        wait_until_drained();
        repeat (4) @(posedge i_clk);

        $display("Checked %0d results over %0d closed frames under %0d polynomials.",
                 checked_results, frames_closed, poly_settings);
        $display("Saw %0d escaped data bytes, %0d escaped CRC bytes, %0d saturated counts,",
                 data_escapes, crc_escapes, saturated_counts);
        $display("and %0d input stall cycles.", input_stalls);
        if (error_count == 0 && owed_results.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
